// ===== rtl/keyboard_scancode_decoder_defines.svh =====
// Assertion helpers for the keyboard decoder.
`ifndef KEYBOARD_SCANCODE_DECODER_DEFINES_SVH
`define KEYBOARD_SCANCODE_DECODER_DEFINES_SVH

// Same-cycle implication.
`define KBD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kbd_pkg.sv =====
package kbd_pkg;

   localparam int KEY_W  = 8;
   localparam int CHAR_W = 7;
   localparam int LOCK_W = 3;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_SYNC = 1'b1
   } op_type;

   localparam logic [KEY_W-1:0] SC_TAB         = 8'h0F;
   localparam logic [KEY_W-1:0] SC_LSHIFT_MAKE = 8'h2A;
   localparam logic [KEY_W-1:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [KEY_W-1:0] SC_LSHIFT_BRK  = 8'hAA;
   localparam logic [KEY_W-1:0] SC_RSHIFT_BRK  = 8'hB6;
   localparam logic [KEY_W-1:0] SC_CAPS        = 8'h3A;
   localparam logic [KEY_W-1:0] SC_NUM         = 8'h45;
   localparam logic [KEY_W-1:0] SC_SCROLL      = 8'h46;
   localparam logic [KEY_W-1:0] SC_F1          = 8'h3B;
   localparam logic [KEY_W-1:0] SC_F11         = 8'h57;
   localparam logic [KEY_W-1:0] KBD_ACK        = 8'hFA;
   localparam logic [KEY_W-1:0] KBD_RESEND     = 8'hFE;
   localparam logic [KEY_W-1:0] LED_CMD        = 8'hED;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CASE    = 7'h20;

   localparam int LOCK_CAPS   = 2;
   localparam int LOCK_NUM    = 1;
   localparam int LOCK_SCROLL = 0;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              char_valid;
      logic              focus_next;
      logic              break_request;
      logic              raise_window;
      logic              send_valid;
      logic [KEY_W-1:0]  send_byte;
      logic [LOCK_W-1:0] lock_bits;
   } rsp_payload_type;

   function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'h02, 7'h4F: ch = 7'h31;
         7'h03, 7'h50: ch = 7'h32;
         7'h04, 7'h51: ch = 7'h33;
         7'h05, 7'h4B: ch = 7'h34;
         7'h06, 7'h4C: ch = 7'h35;
         7'h07, 7'h4D: ch = 7'h36;
         7'h08, 7'h47: ch = 7'h37;
         7'h09, 7'h48: ch = 7'h38;
         7'h0A, 7'h49: ch = 7'h39;
         7'h0B, 7'h52: ch = 7'h30;
         7'h0C, 7'h4A: ch = 7'h2D;
         7'h0D: ch = 7'h5E;
         7'h0E: ch = 7'h08;
         7'h10: ch = 7'h51;
         7'h11: ch = 7'h57;
         7'h12: ch = 7'h45;
         7'h13: ch = 7'h52;
         7'h14: ch = 7'h54;
         7'h15: ch = 7'h59;
         7'h16: ch = 7'h55;
         7'h17: ch = 7'h49;
         7'h18: ch = 7'h4F;
         7'h19: ch = 7'h50;
         7'h1A: ch = 7'h40;
         7'h1B: ch = 7'h5B;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h41;
         7'h1F: ch = 7'h53;
         7'h20: ch = 7'h44;
         7'h21: ch = 7'h46;
         7'h22: ch = 7'h47;
         7'h23: ch = 7'h48;
         7'h24: ch = 7'h4A;
         7'h25: ch = 7'h4B;
         7'h26: ch = 7'h4C;
         7'h27: ch = 7'h3B;
         7'h28: ch = 7'h3A;
         7'h2B: ch = 7'h5D;
         7'h2C: ch = 7'h5A;
         7'h2D: ch = 7'h58;
         7'h2E: ch = 7'h43;
         7'h2F: ch = 7'h56;
         7'h30: ch = 7'h42;
         7'h31: ch = 7'h4E;
         7'h32: ch = 7'h4D;
         7'h33: ch = 7'h2C;
         7'h34, 7'h53: ch = 7'h2E;
         7'h35: ch = 7'h2F;
         7'h37: ch = 7'h2A;
         7'h39: ch = 7'h20;
         7'h4E: ch = 7'h2B;
         7'h73, 7'h7D: ch = 7'h5C;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   // Only the keys whose shifted glyph differs are listed here.
   function automatic logic [CHAR_W-1:0] shifted_char(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'h02: ch = 7'h21;
         7'h03: ch = 7'h22;
         7'h04: ch = 7'h23;
         7'h05: ch = 7'h24;
         7'h06: ch = 7'h25;
         7'h07: ch = 7'h26;
         7'h08: ch = 7'h27;
         7'h09: ch = 7'h28;
         7'h0A: ch = 7'h29;
         7'h0B, 7'h0D: ch = 7'h7E;
         7'h0C: ch = 7'h3D;
         7'h1A: ch = 7'h60;
         7'h1B: ch = 7'h7B;
         7'h27: ch = 7'h2B;
         7'h28: ch = 7'h2A;
         7'h2B: ch = 7'h7D;
         7'h33: ch = 7'h3C;
         7'h34: ch = 7'h3E;
         7'h35: ch = 7'h3F;
         7'h73: ch = 7'h5F;
         7'h7D: ch = 7'h7C;
         default: ch = plain_char(code);
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/kbd_intf.sv =====
interface kbd_req_if import kbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [KEY_W-1:0] key_byte;

   modport source (output valid, output op, output key_byte, input ready);
   modport sink   (input valid, input op, input key_byte, output ready);
endinterface

interface kbd_rsp_if import kbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              char_valid;
   logic              focus_next;
   logic              break_request;
   logic              raise_window;
   logic              send_valid;
   logic [KEY_W-1:0]  send_byte;
   logic [LOCK_W-1:0] lock_bits;

   modport source (output valid, output char_code, output char_valid, output focus_next,
                   output break_request, output raise_window, output send_valid,
                   output send_byte, output lock_bits, input ready);
   modport sink   (input valid, input char_code, input char_valid, input focus_next,
                   input break_request, input raise_window, input send_valid,
                   input send_byte, input lock_bits, output ready);
endinterface

interface kbd_csr_if import kbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LOCK_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/keyboard_scancode_decoder.sv =====
// Each result is registered in rsp_ff when its transaction is accepted.
// One transaction per cycle while output is taken; input ready follows the output register.
// LED command bytes sit in two interleaved memory banks (one write port each), so
// both bytes of an LED command are stored in the same cycle; the head is read ahead.
// Reset (synchronous) clears shift, lock, sender and queue pointers; queue contents
// stay undefined and need no clearing pass.
`include "keyboard_scancode_decoder_defines.svh"

module keyboard_scancode_decoder import kbd_pkg::*; #(
   parameter int CMD_QUEUE_DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   kbd_req_if.sink   req_chan,
   kbd_rsp_if.source rsp_chan,
   kbd_csr_if.sink   csr_chan
);

   // Ring is even and at least 4 so entries interleave cleanly over two banks.
   localparam int RING  = (CMD_QUEUE_DEPTH < 4) ? 4 : CMD_QUEUE_DEPTH + (CMD_QUEUE_DEPTH % 2);
   localparam int PTR_W = $clog2(RING);
   localparam int ROW_W = PTR_W - 1;
   localparam int ROWS  = RING / 2;
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam logic [PTR_W-1:0] RING_LAST = PTR_W'(RING - 1);
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(CMD_QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(CMD_QUEUE_DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == RING_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   logic [1:0]        shift_ff, shift_in;
   logic [LOCK_W-1:0] lock_ff, lock_in;
   logic [LOCK_W-1:0] init_lock_ff;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              await_ff, await_in;
   logic [KEY_W-1:0]  last_sent_ff, last_sent_in;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff, rsp_in;
   logic              byp_hit_ff, byp_hit_in;
   logic [KEY_W-1:0]  byp_data_ff, byp_data_in;

   logic [KEY_W-1:0]  bank0_ff [ROWS];
   logic [KEY_W-1:0]  bank1_ff [ROWS];
   logic [KEY_W-1:0]  bank0_rd_ff, bank1_rd_ff;

   logic              accept;
   logic              is_key;
   logic [KEY_W-1:0]  kb;
   logic [CHAR_W-1:0] map_ch, ch;
   logic              led_req, push1, push2, resend, pop, await_mid;
   logic [CNT_W-1:0]  count_mid;
   logic [PTR_W-1:0]  wr1;
   logic [KEY_W-1:0]  head, pop_byte, send_byte;
   logic              b0_we, b1_we;
   logic [ROW_W-1:0]  b0_row, b1_row;
   logic [KEY_W-1:0]  b0_data, b1_data;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.char_code     = rsp_ff.char_code;
   assign rsp_chan.char_valid    = rsp_ff.char_valid;
   assign rsp_chan.focus_next    = rsp_ff.focus_next;
   assign rsp_chan.break_request = rsp_ff.break_request;
   assign rsp_chan.raise_window  = rsp_ff.raise_window;
   assign rsp_chan.send_valid    = rsp_ff.send_valid;
   assign rsp_chan.send_byte     = rsp_ff.send_byte;
   assign rsp_chan.lock_bits     = rsp_ff.lock_bits;

   // Head of queue: registered bank read, or a byte written in the same cycle it was read.
   assign head = byp_hit_ff ? byp_data_ff : (rd_ff[0] ? bank1_rd_ff : bank0_rd_ff);

   always_comb begin
      is_key = (req_chan.op == OP_KEY);
      kb     = req_chan.key_byte;
      map_ch = (shift_ff == 2'b00) ? plain_char(kb[CHAR_W-1:0])
                                   : shifted_char(kb[CHAR_W-1:0]);
      ch = '0;
      if (is_key && !kb[KEY_W-1]) begin
         ch = map_ch;
         if (map_ch >= CHAR_UPPER_A && map_ch <= CHAR_UPPER_Z &&
             lock_ff[LOCK_CAPS] == (shift_ff != 2'b00)) begin
            ch = map_ch + CHAR_CASE;
         end
      end

      shift_in  = shift_ff;
      lock_in   = lock_ff;
      led_req   = 1'b0;
      await_mid = await_ff;
      resend    = 1'b0;
      if (!is_key) begin
         lock_in = init_lock_ff;
         led_req = 1'b1;
      end else begin
         case (kb)
            SC_LSHIFT_MAKE: shift_in[0] = 1'b1;
            SC_RSHIFT_MAKE: shift_in[1] = 1'b1;
            SC_LSHIFT_BRK:  shift_in[0] = 1'b0;
            SC_RSHIFT_BRK:  shift_in[1] = 1'b0;
            SC_CAPS: begin
               lock_in[LOCK_CAPS] = ~lock_ff[LOCK_CAPS];
               led_req            = 1'b1;
            end
            SC_NUM: begin
               lock_in[LOCK_NUM] = ~lock_ff[LOCK_NUM];
               led_req           = 1'b1;
            end
            SC_SCROLL: begin
               lock_in[LOCK_SCROLL] = ~lock_ff[LOCK_SCROLL];
               led_req              = 1'b1;
            end
            KBD_ACK:    await_mid = 1'b0;
            KBD_RESEND: resend    = await_ff;
            default: ;
         endcase
      end

      // Second byte of the LED command only fits if the first one did.
      push1     = led_req && (count_ff < DEPTH_C);
      push2     = led_req && (count_ff < DEPTH_M1);
      count_mid = count_ff + CNT_W'(push1) + CNT_W'(push2);
      pop       = !resend && !await_mid && (count_mid != '0);
      // Empty queue before this transaction: the oldest byte is the LED command just queued.
      pop_byte  = (count_ff != '0) ? head : LED_CMD;
      send_byte = resend ? last_sent_ff : (pop ? pop_byte : '0);

      wr1     = ptr_inc(wr_ff);
      b0_we   = accept && ((push1 && !wr_ff[0]) || (push2 && !wr1[0]));
      b1_we   = accept && ((push1 && wr_ff[0]) || (push2 && wr1[0]));
      b0_row  = !wr_ff[0] ? wr_ff[PTR_W-1:1] : wr1[PTR_W-1:1];
      b1_row  = wr_ff[0] ? wr_ff[PTR_W-1:1] : wr1[PTR_W-1:1];
      b0_data = !wr_ff[0] ? LED_CMD : KEY_W'(lock_in);
      b1_data = wr_ff[0] ? LED_CMD : KEY_W'(lock_in);

      shift_in     = accept ? shift_in : shift_ff;
      lock_in      = accept ? lock_in : lock_ff;
      rd_in        = (accept && pop) ? ptr_inc(rd_ff) : rd_ff;
      wr_in        = wr_ff;
      if (accept && push2) begin
         wr_in = ptr_inc(wr1);
      end else if (accept && push1) begin
         wr_in = wr1;
      end
      count_in     = accept ? count_mid - CNT_W'(pop) : count_ff;
      await_in     = accept ? (await_mid || pop) : await_ff;
      last_sent_in = (accept && pop) ? pop_byte : last_sent_ff;

      byp_hit_in  = 1'b0;
      byp_data_in = b0_data;
      if (b0_we && {b0_row, 1'b0} == rd_in) begin
         byp_hit_in = 1'b1;
      end else if (b1_we && {b1_row, 1'b1} == rd_in) begin
         byp_hit_in  = 1'b1;
         byp_data_in = b1_data;
      end

      rsp_in.char_code     = ch;
      rsp_in.char_valid    = (ch != '0);
      rsp_in.focus_next    = is_key && (kb == SC_TAB);
      rsp_in.break_request = is_key && (kb == SC_F1) && (shift_in != 2'b00);
      rsp_in.raise_window  = is_key && (kb == SC_F11);
      rsp_in.send_valid    = resend || pop;
      rsp_in.send_byte     = send_byte;
      rsp_in.lock_bits     = lock_in;
   end

   always_ff @(posedge clock) begin
      if (b0_we) begin
         bank0_ff[b0_row] <= b0_data;
      end
      bank0_rd_ff <= bank0_ff[rd_in[PTR_W-1:1]];
   end

   always_ff @(posedge clock) begin
      if (b1_we) begin
         bank1_ff[b1_row] <= b1_data;
      end
      bank1_rd_ff <= bank1_ff[rd_in[PTR_W-1:1]];
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         shift_ff     <= '0;
         lock_ff      <= '0;
         init_lock_ff <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         count_ff     <= '0;
         await_ff     <= 1'b0;
         last_sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         lock_ff      <= lock_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         count_ff     <= count_in;
         await_ff     <= await_in;
         last_sent_ff <= last_sent_in;
         byp_hit_ff   <= byp_hit_in;
         if (csr_chan.valid && csr_chan.ready) begin
            init_lock_ff <= csr_chan.data;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `KBD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C,
                   "queue count overflow")
   `KBD_ASSERT_NEXT(a_pop_waits, clock, reset, accept && pop, await_ff,
                    "sender not waiting after send")
   `KBD_ASSERT_NEXT(a_resend_byte, clock, reset, accept && resend,
                    rsp_ff.send_valid && rsp_ff.send_byte == $past(last_sent_ff),
                    "resend byte mismatch")

endmodule

// ===== tb/tb_keyboard_scancode_decoder.sv =====
module tb_keyboard_scancode_decoder;
   import kbd_pkg::*;

   localparam int CMD_DEPTH      = 32;
   localparam int ITEMS_PER_PASS = 200;
   localparam int PASSES         = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 10;

   // Set 1 key maps, entry 0 first.
   localparam logic [8*128-1:0] PLAIN_KEYS = {
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
      8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, {12{8'h00}},
      {16{8'h00}},
      8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
   };

   localparam logic [8*128-1:0] SHIFT_KEYS = {
      8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
      8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
      8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, {12{8'h00}},
      {16{8'h00}},
      8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
   };

   typedef struct packed {
      op_type          op;
      logic [7:0]      key;
      logic            typed;
      rsp_payload_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   kbd_req_if req_if ();
   kbd_rsp_if rsp_if ();
   kbd_csr_if csr_if ();

   keyboard_scancode_decoder #(.CMD_QUEUE_DEPTH(CMD_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #2 clock = ~clock;

   // decoder mirror
   logic [1:0]      shift_keys  = '0;
   logic [2:0]      locks       = '0;
   logic [2:0]      boot_locks  = '0;
   logic [7:0]      cmd_bytes[$];
   logic            waiting_ack = 1'b0;
   logic [7:0]      last_sent   = '0;

   rsp_payload_type expected_chars[$];
   stim_row_type    directed_rows[$];
   logic            row_typed;
   rsp_payload_type row_want;

   int mismatches  = 0;
   int rsp_count   = 0;
   int items_sent  = 0;
   int idle_one_in = 3;
   int quiet_count = 0;

   function automatic void push_command(logic [7:0] b);
      if (cmd_bytes.size() < CMD_DEPTH)
         cmd_bytes.push_back(b);
   endfunction

   function automatic void queue_led_update();
      push_command(LED_CMD);
      push_command({5'b0, locks});
   endfunction

   function automatic rsp_payload_type decode_key(op_type op, logic [7:0] key);
      rsp_payload_type r;
      logic [7:0]      glyph;
      logic            resend;
      r      = '0;
      resend = 1'b0;
      if (op == OP_SYNC) begin
         locks = boot_locks;
         queue_led_update();
      end else begin
         if (!key[7]) begin
            if (shift_keys == 2'b00)
               glyph = PLAIN_KEYS[8*(127 - key[6:0]) +: 8];
            else
               glyph = SHIFT_KEYS[8*(127 - key[6:0]) +: 8];
            // lower case unless exactly one of caps and shift is active
            if (glyph >= CHAR_UPPER_A && glyph <= CHAR_UPPER_Z &&
                locks[LOCK_CAPS] == (shift_keys != 2'b00))
               glyph = glyph + CHAR_CASE;
            r.char_code = glyph[6:0];
         end
         case (key)
            SC_TAB:         r.focus_next = 1'b1;
            SC_LSHIFT_MAKE: shift_keys[0] = 1'b1;
            SC_RSHIFT_MAKE: shift_keys[1] = 1'b1;
            SC_LSHIFT_BRK:  shift_keys[0] = 1'b0;
            SC_RSHIFT_BRK:  shift_keys[1] = 1'b0;
            SC_CAPS: begin
               locks[LOCK_CAPS] = ~locks[LOCK_CAPS];
               queue_led_update();
            end
            SC_NUM: begin
               locks[LOCK_NUM] = ~locks[LOCK_NUM];
               queue_led_update();
            end
            SC_SCROLL: begin
               locks[LOCK_SCROLL] = ~locks[LOCK_SCROLL];
               queue_led_update();
            end
            SC_F1:      r.break_request = (shift_keys != 2'b00);
            SC_F11:     r.raise_window = 1'b1;
            KBD_ACK:    waiting_ack = 1'b0;
            KBD_RESEND: resend = waiting_ack;
            default: ;
         endcase
      end
      if (resend) begin
         r.send_valid = 1'b1;
         r.send_byte  = last_sent;
      end else if (!waiting_ack && cmd_bytes.size() != 0) begin
         last_sent    = cmd_bytes.pop_front();
         waiting_ack  = 1'b1;
         r.send_valid = 1'b1;
         r.send_byte  = last_sent;
      end
      r.char_valid = (r.char_code != '0);
      r.lock_bits  = locks;
      return r;
   endfunction

   function automatic rsp_payload_type quiet_result(logic [6:0] ch, logic [2:0] flags);
      rsp_payload_type r;
      r               = '0;
      r.char_code     = ch;
      r.char_valid    = (ch != '0);
      r.focus_next    = flags[2];
      r.break_request = flags[1];
      r.raise_window  = flags[0];
      return r;
   endfunction

   function automatic stim_row_type stim(op_type op, logic [7:0] key, logic typed = 1'b0,
                                         rsp_payload_type want = '0);
      stim_row_type s;
      s.op    = op;
      s.key   = key;
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   function automatic logic [7:0] pick_lock_key();
      case ($urandom_range(0, 2))
         0:       return SC_CAPS;
         1:       return SC_NUM;
         default: return SC_SCROLL;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [7:0] seen, logic [7:0] want);
      if (seen !== want)
         report_mismatch($sformatf("rsp %0d %s got %0h want %0h", rsp_count, name, seen, want));
   endtask

   task automatic send_key(op_type op, logic [7:0] key, logic typed = 1'b0,
                           rsp_payload_type want = '0);
      if (idle_one_in != 0 && $urandom_range(1, idle_one_in) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.key_byte <= key;
      row_typed       <= typed;
      row_want        <= want;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic write_boot_locks(logic [2:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
   endtask

   task automatic play_sequence();
      int         kind;
      int         n;
      logic [7:0] code;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         code = 8'($urandom_range(0, 127));
         send_key(OP_KEY, code);
         send_key(OP_KEY, code | 8'h80);
      end else if (kind < 45) begin
         code = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
         send_key(OP_KEY, code);
         n = $urandom_range(1, 3);
         repeat (n) send_key(OP_KEY, 8'($urandom_range(0, 127)));
         send_key(OP_KEY, (code == SC_LSHIFT_MAKE) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK);
      end else if (kind < 60) begin
         // LED exchange: command byte, optional resend, then both acks
         send_key(OP_KEY, pick_lock_key());
         if ($urandom_range(0, 2) == 0)
            send_key(OP_KEY, KBD_RESEND);
         send_key(OP_KEY, KBD_ACK);
         send_key(OP_KEY, KBD_ACK);
      end else if (kind < 66) begin
         // unacked lock presses pile up and can fill the queue
         n = $urandom_range(1, 20);
         repeat (n) send_key(OP_KEY, pick_lock_key());
      end else if (kind < 80) begin
         n = $urandom_range(1, 6);
         repeat (n) send_key(OP_KEY, $urandom_range(0, 3) != 0 ? KBD_ACK : KBD_RESEND);
      end else if (kind < 86) begin
         send_key(OP_SYNC, 8'($urandom_range(0, 255)));
      end else begin
         send_key(OP_KEY, 8'($urandom_range(0, 255)));
      end
   endtask

   // response side back-pressure
   initial begin
      int gap;
      gap = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (gap > 0)
            gap--;
         else if (idle_one_in != 0 && $urandom_range(1, idle_one_in + 4) == 1)
            gap = $urandom_range(1, 8);
         rsp_if.ready <= (gap == 0);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type seen;
      rsp_payload_type want;
      logic            moved;
      moved = 1'b0;
      if (reset) begin
         quiet_count = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            boot_locks = csr_if.data;
            moved      = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            want = decode_key(op_type'(req_if.op), req_if.key_byte);
            expected_chars.push_back(row_typed ? row_want : want);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen.char_code     = rsp_if.char_code;
            seen.char_valid    = rsp_if.char_valid;
            seen.focus_next    = rsp_if.focus_next;
            seen.break_request = rsp_if.break_request;
            seen.raise_window  = rsp_if.raise_window;
            seen.send_valid    = rsp_if.send_valid;
            seen.send_byte     = rsp_if.send_byte;
            seen.lock_bits     = rsp_if.lock_bits;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("rsp %0d arrived with nothing pending", rsp_count));
            end else begin
               want = expected_chars.pop_front();
               check_field("char_code", 8'(seen.char_code), 8'(want.char_code));
               check_field("char_valid", 8'(seen.char_valid), 8'(want.char_valid));
               check_field("focus_next", 8'(seen.focus_next), 8'(want.focus_next));
               check_field("break_request", 8'(seen.break_request),
                           8'(want.break_request));
               check_field("raise_window", 8'(seen.raise_window), 8'(want.raise_window));
               check_field("send_valid", 8'(seen.send_valid), 8'(want.send_valid));
               check_field("send_byte", seen.send_byte, want.send_byte);
               check_field("lock_bits", 8'(seen.lock_bits), 8'(want.lock_bits));
            end
            rsp_count++;
            moved = 1'b1;
         end
         quiet_count = moved ? 0 : quiet_count + 1;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.op       <= OP_KEY;
      req_if.key_byte <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.data     <= '0;
      row_typed       <= 1'b0;
      row_want        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back(stim(OP_KEY, 8'h00, 1'b1, quiet_result(7'h00, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, 8'hFF, 1'b1, quiet_result(7'h00, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, 8'h7F, 1'b1, quiet_result(7'h00, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, 8'h80, 1'b1, quiet_result(7'h00, 3'b000)));
      // ack and resend with nothing in flight
      directed_rows.push_back(stim(OP_KEY, KBD_RESEND, 1'b1, quiet_result(7'h00, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, KBD_ACK, 1'b1, quiet_result(7'h00, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, 8'h1E, 1'b1, quiet_result(7'h61, 3'b000)));
      directed_rows.push_back(stim(OP_KEY, SC_TAB, 1'b1, quiet_result(7'h00, 3'b100)));
      directed_rows.push_back(stim(OP_KEY, SC_F11, 1'b1, quiet_result(7'h00, 3'b001)));
      directed_rows.push_back(stim(OP_KEY, SC_F1));
      directed_rows.push_back(stim(OP_KEY, SC_LSHIFT_MAKE));
      directed_rows.push_back(stim(OP_KEY, SC_F1));
      directed_rows.push_back(stim(OP_KEY, 8'h1E));
      directed_rows.push_back(stim(OP_KEY, 8'h02));
      directed_rows.push_back(stim(OP_KEY, SC_RSHIFT_MAKE));
      directed_rows.push_back(stim(OP_KEY, SC_LSHIFT_BRK));
      directed_rows.push_back(stim(OP_KEY, 8'h0D));
      directed_rows.push_back(stim(OP_KEY, 8'h73));
      directed_rows.push_back(stim(OP_KEY, SC_RSHIFT_BRK));
      directed_rows.push_back(stim(OP_KEY, SC_CAPS));
      directed_rows.push_back(stim(OP_KEY, 8'h1E));
      directed_rows.push_back(stim(OP_KEY, KBD_RESEND));
      directed_rows.push_back(stim(OP_KEY, KBD_ACK));
      directed_rows.push_back(stim(OP_KEY, SC_NUM));
      directed_rows.push_back(stim(OP_KEY, KBD_ACK));
      directed_rows.push_back(stim(OP_KEY, SC_SCROLL));
      directed_rows.push_back(stim(OP_SYNC, 8'hC3));

      write_boot_locks(3'd5);
      foreach (directed_rows[i])
         send_key(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                  directed_rows[i].want);

      for (int pass = 0; pass < PASSES; pass++) begin
         if (pass == 0)
            write_boot_locks(3'd7);
         else if (pass == 1)
            write_boot_locks(3'd0);
         else
            write_boot_locks(3'($urandom_range(0, 7)));
         if (pass == PASSES - 1 || pass == 2)
            idle_one_in = 0;
         else
            idle_one_in = $urandom_range(2, 8);
         while (items_sent < directed_rows.size() + (pass + 1) * ITEMS_PER_PASS)
            play_sequence();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
